@@ sv/ax25_frame_header_parser_defines.svh @@
`ifndef AX25_FRAME_HEADER_PARSER_DEFINES_SVH
`define AX25_FRAME_HEADER_PARSER_DEFINES_SVH

// same-cycle implication, checked on every clock outside reset
`define AXFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AXFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/axfp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package axfp_pkg;

  // result kinds
  localparam logic [1:0] KIND_REJECT  = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_HOP     = 2'd2;

  // frame types
  localparam logic [1:0] FT_I = 2'd0;
  localparam logic [1:0] FT_S = 2'd1;
  localparam logic [1:0] FT_U = 2'd2;

  // U frame control values that carry a PID (P/F bit masked)
  localparam logic [7:0] CTRL_UI    = 8'h03;
  localparam logic [7:0] CTRL_XID   = 8'hAF;
  localparam logic [7:0] CTRL_PF_MASK = 8'hEF;

  localparam int ADDR_W     = 47;
  localparam int CALL_W     = 42;
  localparam int CTRL_OFFS  = 14;
  localparam int MIN_LEN    = 15;
  localparam int GROUP_LAST = 6;

  // frame summary handed from front to back
  typedef struct packed {
    logic              reject;
    logic [1:0]        frame_type;
    logic [ADDR_W-1:0] dst;
    logic [ADDR_W-1:0] src;
    logic              ext;
    logic              has_pid;
    logic              ovf;
    logic [15:0]       ctrl_word;
    logic [7:0]        pid;
    logic [11:0]       info_start;
    logic [11:0]       info_count;
  } summary_t;

endpackage
`default_nettype wire

@@ sv/axfp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module axfp_front import axfp_pkg::*; #(
  parameter int MAX_HOPS = 8,
  parameter int MAX_FRAME_BYTES = 2048,
  parameter int HC_W = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       extended_mode,
  input  wire logic                       take,
  input  wire logic [7:0]                 byte_value,
  input  wire logic                       end_of_frame,
  output logic                            push,
  output summary_t                        rec_sum,
  output logic [HC_W-1:0]                 rec_hops,
  output logic [MAX_HOPS*ADDR_W-1:0]      rec_addr
);

  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int SW    = POS_W + 2;
  localparam int HI_W  = (MAX_HOPS > 1) ? $clog2(MAX_HOPS) : 1;
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_FRAME_BYTES);
  localparam logic [POS_W-1:0] OFFS14  = POS_W'(CTRL_OFFS);

  logic [POS_W-1:0]  byte_position, n_pos;
  logic [2:0]        phase, n_phase;
  logic [ADDR_W-1:0] dst_address, n_dst;
  logic [ADDR_W-1:0] src_address, n_src;
  logic [CALL_W-1:0] group_collector, n_coll;
  logic [ADDR_W-1:0] hop_store [MAX_HOPS];
  logic [ADDR_W-1:0] hop_snap  [MAX_HOPS];
  logic [HC_W-1:0]   hop_count, n_hc;
  logic              address_end_seen, n_aes;
  logic [POS_W-1:0]  control_offset, n_coff;
  logic [23:0]       control_bytes, n_cb;
  logic [23:0]       fallback_bytes, n_fb;
  logic              overflow_seen, n_ovf;
  logic              hop_we;
  logic [ADDR_W-1:0] addr_word;
  logic [POS_W-1:0]  cdist;

  // absorb one byte
  always_comb begin
    n_pos = byte_position; n_phase = phase; n_dst = dst_address; n_src = src_address;
    n_coll = group_collector; n_hc = hop_count; n_aes = address_end_seen;
    n_coff = control_offset; n_cb = control_bytes; n_fb = fallback_bytes;
    n_ovf = overflow_seen; hop_we = 1'b0;
    addr_word = {group_collector, byte_value[4:1], byte_value[7]};
    cdist = byte_position - control_offset;
    if (byte_position >= MAX_POS) begin
      n_ovf = 1'b1;
    end else begin
      n_pos = byte_position + POS_W'(1);
      n_phase = (phase == 3'(GROUP_LAST)) ? 3'd0 : phase + 3'd1;
      if (byte_position == OFFS14)             n_fb[7:0]   = byte_value;
      if (byte_position == OFFS14 + POS_W'(1)) n_fb[15:8]  = byte_value;
      if (byte_position == OFFS14 + POS_W'(2)) n_fb[23:16] = byte_value;
      if (address_end_seen && byte_position >= control_offset) begin
        case (cdist)
          POS_W'(0): n_cb[7:0]   = byte_value;
          POS_W'(1): n_cb[15:8]  = byte_value;
          POS_W'(2): n_cb[23:16] = byte_value;
          default: ;
        endcase
      end
      // address walk
      if (byte_position < OFFS14 || !address_end_seen) begin
        if (phase != 3'(GROUP_LAST)) begin
          n_coll = {group_collector[CALL_W-8:0], byte_value[7:1]};
        end else begin
          if (byte_position == POS_W'(GROUP_LAST)) begin
            n_dst = addr_word;
          end else if (byte_position == POS_W'(CTRL_OFFS - 1)) begin
            n_src = addr_word;
            if (byte_value[0]) begin
              n_aes = 1'b1;
              n_coff = OFFS14;
            end
          end else begin
            if (hop_count < HC_W'(MAX_HOPS)) begin
              hop_we = 1'b1;
              n_hc = hop_count + HC_W'(1);
            end else begin
              n_ovf = 1'b1;
            end
            if (byte_value[0]) begin
              n_aes = 1'b1;
              n_coff = byte_position + POS_W'(1);
            end
          end
          n_coll = '0;
        end
      end
    end
  end

  // hop store including this cycle's write
  always_comb begin
    for (int i = 0; i < MAX_HOPS; i++) begin
      hop_snap[i] = hop_store[i];
      if (hop_we && hop_count[HI_W-1:0] == HI_W'(i)) hop_snap[i] = addr_word;
      rec_addr[i*ADDR_W +: ADDR_W] = hop_snap[i];
    end
  end

  // frame end decode
  logic [SW-1:0] len, ctrl, po;
  logic [23:0]   cb;
  logic [7:0]    c;
  logic [1:0]    ft;
  logic          ext_is, pid_slot, rej;
  always_comb begin
    len = SW'(n_pos);
    ctrl = n_aes ? SW'(n_coff) : SW'(CTRL_OFFS);
    cb = n_aes ? n_cb : n_fb;
    c = cb[7:0];
    ft = !c[0] ? FT_I : ((c[1:0] == 2'b01) ? FT_S : FT_U);
    ext_is = extended_mode && ft != FT_U;
    po = ctrl + (ext_is ? SW'(2) : SW'(1));
    pid_slot = (ft == FT_I) ||
               (ft == FT_U && ((c & CTRL_PF_MASK) == CTRL_UI ||
                               (c & CTRL_PF_MASK) == CTRL_XID));
    rej = len < SW'(MIN_LEN) || ctrl >= len || (ext_is && ctrl + SW'(1) >= len);
    rec_sum = '0;
    rec_sum.reject = rej;
    rec_sum.frame_type = ft;
    rec_sum.dst = n_dst;
    rec_sum.src = n_src;
    rec_sum.ext = ext_is;
    rec_sum.ovf = n_ovf;
    rec_sum.ctrl_word = {ext_is ? cb[15:8] : 8'h00, c};
    if (pid_slot && po < len) begin
      rec_sum.has_pid = 1'b1;
      rec_sum.pid = ext_is ? cb[23:16] : cb[15:8];
      if (po + SW'(1) < len) begin
        rec_sum.info_start = 12'(po + SW'(1));
        rec_sum.info_count = 12'(len - po - SW'(1));
      end
    end
    rec_hops = (n_aes && !rej) ? n_hc : '0;
    push = take && end_of_frame;
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst || push) begin
      byte_position <= '0; phase <= '0; dst_address <= '0; src_address <= '0;
      group_collector <= '0; hop_count <= '0; address_end_seen <= 1'b0;
      control_offset <= OFFS14; control_bytes <= '0; fallback_bytes <= '0;
      overflow_seen <= 1'b0;
    end else if (take) begin
      byte_position <= n_pos; phase <= n_phase; dst_address <= n_dst;
      src_address <= n_src; group_collector <= n_coll; hop_count <= n_hc;
      address_end_seen <= n_aes; control_offset <= n_coff; control_bytes <= n_cb;
      fallback_bytes <= n_fb; overflow_seen <= n_ovf;
    end
  end

  // hop store, no reset
  always_ff @(posedge clk) begin
    if (take && hop_we) hop_store[hop_count[HI_W-1:0]] <= addr_word;
  end

endmodule
`default_nettype wire

@@ sv/axfp_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module axfp_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  input  wire logic         pop,
  output logic              full,
  output logic              not_empty,
  output logic [W-1:0]      head
);

  logic [W-1:0] slot [2];
  logic         wr_ptr, rd_ptr;
  logic [1:0]   count;

  assign full = count == 2'd2;
  assign not_empty = count != 2'd0;
  assign head = slot[rd_ptr];

  // two-entry record queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0; rd_ptr <= 1'b0; count <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_data;
  end

endmodule
`default_nettype wire

@@ sv/axfp_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module axfp_back import axfp_pkg::*; #(
  parameter int MAX_HOPS = 8,
  parameter int HC_W = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  q_valid,
  input  wire summary_t              q_sum,
  input  wire logic [HC_W-1:0]       q_hops,
  input  wire logic [MAX_HOPS*ADDR_W-1:0] q_addr,
  output logic                       pop,
  input  wire logic                  out_stall,
  output logic                       out_valid,
  output logic [1:0]                 kind,
  output logic [1:0]                 frame_type,
  output logic [41:0]                call_a,
  output logic [3:0]                 ssid_a,
  output logic [41:0]                call_b,
  output logic [3:0]                 ssid_b,
  output logic [4:0]                 flags,
  output logic [15:0]                control_word,
  output logic [7:0]                 pid,
  output logic [11:0]                info_start,
  output logic [11:0]                info_count,
  output logic                       last
);

  localparam int HI_W = (MAX_HOPS > 1) ? $clog2(MAX_HOPS) : 1;

  logic [HC_W-1:0]   cursor;
  logic              advance, emit_hop;
  logic [ADDR_W-1:0] hop;

  assign advance = q_valid && (!out_valid || !out_stall);
  assign emit_hop = cursor < q_hops;
  assign pop = advance && !emit_hop;
  assign hop = q_addr[32'(cursor[HI_W-1:0]) * ADDR_W +: ADDR_W];

  // cursor and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) cursor <= emit_hop ? cursor + HC_W'(1) : '0;
      if (advance) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // output item register
  always_ff @(posedge clk) begin
    if (advance) begin
      kind <= KIND_REJECT; frame_type <= '0; call_a <= '0; ssid_a <= '0;
      call_b <= '0; ssid_b <= '0; flags <= '0; control_word <= '0; pid <= '0;
      info_start <= '0; info_count <= '0; last <= 1'b1;
      if (emit_hop) begin
        kind <= KIND_HOP;
        call_a <= hop[ADDR_W-1:5];
        ssid_a <= hop[4:1];
        flags <= {4'b0, hop[0]};
        last <= 1'b0;
      end else if (!q_sum.reject) begin
        kind <= KIND_SUMMARY;
        frame_type <= q_sum.frame_type;
        call_a <= q_sum.dst[ADDR_W-1:5];
        ssid_a <= q_sum.dst[4:1];
        call_b <= q_sum.src[ADDR_W-1:5];
        ssid_b <= q_sum.src[4:1];
        flags <= {q_sum.ovf, q_sum.has_pid, q_sum.ext, q_sum.src[0], q_sum.dst[0]};
        control_word <= q_sum.ctrl_word;
        pid <= q_sum.pid;
        info_start <= q_sum.info_start;
        info_count <= q_sum.info_count;
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/ax25_frame_header_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// channel  | handshake                 | payload
// cfg      | cfg_we                    | cfg_wdata (extended_mode)
// in       | in_valid / in_stall       | byte_value, end_of_frame
// out      | out_valid / out_stall     | kind .. last
//
// One byte per cycle enters the front; a frame end hands one record to a
// two-entry queue. The back emits one item per cycle unless out_stall holds it:
// hops, then the summary, or a lone reject; input stalls while the queue is full.
// Reset is synchronous and clears frame state and extended_mode, but not the hop store.
module ax25_frame_header_parser import axfp_pkg::*; #(
  parameter int MAX_HOPS = 8,
  parameter int MAX_FRAME_BYTES = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  byte_value,
  input  wire logic        end_of_frame,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       kind,
  output logic [1:0]       frame_type,
  output logic [41:0]      call_a,
  output logic [3:0]       ssid_a,
  output logic [41:0]      call_b,
  output logic [3:0]       ssid_b,
  output logic [4:0]       flags,
  output logic [15:0]      control_word,
  output logic [7:0]       pid,
  output logic [11:0]      info_start,
  output logic [11:0]      info_count,
  output logic             last
);

  localparam int HC_W = $clog2(MAX_HOPS + 1);
  localparam int AW   = MAX_HOPS * ADDR_W;
  localparam int QW   = $bits(summary_t) + HC_W + AW;

  logic            extended_mode;
  logic            take, push, pop, q_full, q_valid;
  summary_t        rec_sum, q_sum;
  logic [HC_W-1:0] rec_hops, q_hops;
  logic [AW-1:0]   rec_addr, q_addr;
  logic [QW-1:0]   q_head;

  // config register
  always_ff @(posedge clk) begin
    if (rst) extended_mode <= 1'b0;
    else if (cfg_we) extended_mode <= cfg_wdata;
  end

  assign in_stall = q_full;
  assign take = in_valid && !in_stall;

  axfp_front #(.MAX_HOPS(MAX_HOPS), .MAX_FRAME_BYTES(MAX_FRAME_BYTES), .HC_W(HC_W)) u_front (
    .clk, .rst, .extended_mode, .take, .byte_value, .end_of_frame,
    .push, .rec_sum, .rec_hops, .rec_addr
  );

  axfp_queue #(.W(QW)) u_queue (
    .clk, .rst, .push, .push_data({rec_sum, rec_hops, rec_addr}), .pop,
    .full(q_full), .not_empty(q_valid), .head(q_head)
  );

  assign {q_sum, q_hops, q_addr} = q_head;

  axfp_back #(.MAX_HOPS(MAX_HOPS), .HC_W(HC_W)) u_back (
    .clk, .rst, .q_valid, .q_sum, .q_hops, .q_addr, .pop, .out_stall, .out_valid,
    .kind, .frame_type, .call_a, .ssid_a, .call_b, .ssid_b, .flags, .control_word,
    .pid, .info_start, .info_count, .last
  );

endmodule
`default_nettype wire

@@ sv/axfp_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "ax25_frame_header_parser_defines.svh"
module axfp_checker import axfp_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  kind,
  input wire logic [41:0] call_a,
  input wire logic [4:0]  flags,
  input wire logic        last
);

  // a stalled item stays put
  `AXFP_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(kind) && $stable(last), "stalled item changed")
  // kind code in range
  `AXFP_ASSERT_NOW(a_kind, out_valid, kind == KIND_REJECT || kind == KIND_SUMMARY || kind == KIND_HOP, "bad kind")
  // hops never close a frame
  `AXFP_ASSERT_NOW(a_hop, out_valid && kind == KIND_HOP, !last, "hop marked last")
  // summary and reject close the frame; reject carries nothing
  `AXFP_ASSERT_NOW(a_sum, out_valid && kind == KIND_SUMMARY, last, "summary not last")
  `AXFP_ASSERT_NOW(a_rej, out_valid && kind == KIND_REJECT, last && call_a == '0 && flags == '0, "reject not empty")

endmodule

bind ax25_frame_header_parser axfp_checker u_axfp_checker (
  .clk, .rst, .out_valid, .out_stall, .kind, .call_a, .flags, .last
);
`default_nettype wire

@@ bench/tb_ax25_frame_header_parser.sv @@
`timescale 1ns / 1ps
module tb_ax25_frame_header_parser;
  import axfp_pkg::*;

  localparam int HOP_LIMIT   = 8;
  localparam int FRAME_LIMIT = 2048;
  localparam int WATCHDOG    = 20000;
  localparam int DRAIN_WAIT  = 24;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  frame_type;
    logic [41:0] call_a;
    logic [3:0]  ssid_a;
    logic [41:0] call_b;
    logic [3:0]  ssid_b;
    logic [4:0]  flags;
    logic [15:0] control_word;
    logic [7:0]  pid;
    logic [11:0] info_start;
    logic [11:0] info_count;
    logic        last;
  } parse_result_t;

  // directed row: byte, end marker, and whether a rejection is typed in
  typedef struct {
    logic [7:0] b;
    logic       eof;
    bit         typed_reject;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] byte_value = 8'h00;
  logic end_of_frame = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] kind, frame_type;
  logic [41:0] call_a, call_b;
  logic [3:0] ssid_a, ssid_b;
  logic [4:0] flags;
  logic [15:0] control_word;
  logic [7:0] pid;
  logic [11:0] info_start, info_count;
  logic last;

  ax25_frame_header_parser dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .byte_value(byte_value),
    .end_of_frame(end_of_frame), .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .frame_type(frame_type), .call_a(call_a), .ssid_a(ssid_a),
    .call_b(call_b), .ssid_b(ssid_b), .flags(flags), .control_word(control_word),
    .pid(pid), .info_start(info_start), .info_count(info_count), .last(last)
  );

  always #6 clk = ~clk;

  // parser model state
  logic        ext_mode;
  int          pos_cnt;
  logic [46:0] dst_addr, src_addr;
  logic [41:0] call_acc;
  logic [46:0] hops[HOP_LIMIT];
  int          hop_cnt;
  logic        addr_end;
  int          ctrl_pos;
  logic [23:0] ctrl_bytes, alt_bytes;
  logic        ovf;

  parse_result_t expected_q[$];
  parse_result_t frame_out[$];
  logic [7:0]    frame_bytes[$];

  int send_idle = 0, recv_idle = 0;
  int mismatches = 0, results_seen = 0, frames_sent = 0, bytes_sent = 0;
  int quiet_cycles = 0;

  task automatic clear_parser();
    pos_cnt = 0; dst_addr = '0; src_addr = '0; call_acc = '0; hop_cnt = 0;
    addr_end = 1'b0; ctrl_pos = 14; ctrl_bytes = '0; alt_bytes = '0; ovf = 1'b0;
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    int p;
    logic [46:0] a;
    p = pos_cnt;
    if (p >= FRAME_LIMIT) begin
      ovf = 1'b1;
      return;
    end
    pos_cnt = p + 1;
    if (p >= 14 && p <= 16) alt_bytes |= 24'(b) << (8 * (p - 14));
    if (addr_end && p >= ctrl_pos && p < ctrl_pos + 3)
      ctrl_bytes |= 24'(b) << (8 * (p - ctrl_pos));
    if (p < 14 || !addr_end) begin
      if (p % 7 < 6) begin
        call_acc = {call_acc[34:0], b[7:1]};
      end else begin
        a = {call_acc, b[4:1], b[7]};
        if (p == 6) begin
          dst_addr = a;
        end else if (p == 13) begin
          src_addr = a;
          if (b[0]) begin
            addr_end = 1'b1;
            ctrl_pos = 14;
          end
        end else begin
          if (hop_cnt < HOP_LIMIT) begin
            hops[hop_cnt] = a;
            hop_cnt++;
          end else begin
            ovf = 1'b1;
          end
          if (b[0]) begin
            addr_end = 1'b1;
            ctrl_pos = p + 1;
          end
        end
        call_acc = '0;
      end
    end
  endtask

  // frame end: hop items then summary, or a single rejection
  task automatic close_frame();
    parse_result_t r;
    int len, cpos, nh, clen, po;
    logic [23:0] cb;
    logic [7:0] c;
    logic [1:0] ft;
    logic ext_is, pid_slot, has_pid;
    r = '0;
    len = pos_cnt;
    has_pid = 1'b0;
    pid_slot = 1'b0;
    if (addr_end) begin
      cpos = ctrl_pos; cb = ctrl_bytes; nh = hop_cnt;
    end else begin
      cpos = 14; cb = alt_bytes; nh = 0;
    end
    c = cb[7:0];
    ft = !c[0] ? FT_I : (c[1:0] == 2'b01 ? FT_S : FT_U);
    ext_is = ext_mode && ft != FT_U;
    if (len < MIN_LEN || cpos >= len || (ext_is && cpos + 1 >= len)) begin
      r.last = 1'b1;
      frame_out.insert(frame_out.size(), r);
      return;
    end
    clen = ext_is ? 2 : 1;
    po = cpos + clen;
    if (ft == FT_I) pid_slot = 1'b1;
    else if (ft == FT_U) pid_slot = ((c & CTRL_PF_MASK) == CTRL_UI) ||
                                    ((c & CTRL_PF_MASK) == CTRL_XID);
    if (pid_slot && po < len) begin
      has_pid = 1'b1;
      r.pid = ext_is ? cb[23:16] : cb[15:8];
      if (po + 1 < len) begin
        r.info_start = 12'(po + 1);
        r.info_count = 12'(len - po - 1);
      end
    end
    for (int i = 0; i < nh; i++) begin
      parse_result_t h;
      h = '0;
      h.kind = KIND_HOP;
      h.call_a = hops[i][46:5];
      h.ssid_a = hops[i][4:1];
      h.flags = {4'b0, hops[i][0]};
      frame_out.insert(frame_out.size(), h);
    end
    r.kind = KIND_SUMMARY;
    r.frame_type = ft;
    r.call_a = dst_addr[46:5];
    r.ssid_a = dst_addr[4:1];
    r.call_b = src_addr[46:5];
    r.ssid_b = src_addr[4:1];
    r.flags = {ovf, has_pid, ext_is, src_addr[0], dst_addr[0]};
    r.control_word = {ext_is ? cb[15:8] : 8'h00, c};
    r.last = 1'b1;
    frame_out.insert(frame_out.size(), r);
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic eof);
    frame_out.delete();
    absorb_byte(b);
    if (eof) begin
      close_frame();
      clear_parser();
    end
  endtask

  // drive one item and wait for it to be taken
  task automatic send_byte(input logic [7:0] b, input logic eof, input bit typed_reject);
    parse_result_t r;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_value <= b;
    end_of_frame <= eof;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    predict_byte(b, eof);
    if (typed_reject) begin
      r = '0;
      r.last = 1'b1;
      frame_out.delete();
      frame_out.insert(frame_out.size(), r);
    end
    foreach (frame_out[i]) expected_q.insert(expected_q.size(), frame_out[i]);
    if (eof) frames_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_ext(input logic v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    ext_mode = v;
    cfg_we <= 1'b0;
  endtask

  // assemble a random frame into frame_bytes
  task automatic build_frame(input int pad_to);
    int nh, full, kind_sel;
    bit end_ok;
    logic [7:0] ctl;
    frame_bytes.delete();
    if ($urandom_range(9) == 0) begin
      // noise
      repeat ($urandom_range(1, 20)) frame_bytes.insert(frame_bytes.size(), 8'($urandom));
      return;
    end
    nh = ($urandom_range(5) == 0) ? $urandom_range(7, 10) : $urandom_range(0, 3);
    end_ok = $urandom_range(9) != 0;
    for (int g = 0; g < nh + 2; g++) begin
      repeat (6) frame_bytes.insert(frame_bytes.size(), 8'($urandom));
      ctl = 8'($urandom);
      ctl[0] = (g == nh + 1) && end_ok;
      frame_bytes.insert(frame_bytes.size(), ctl);
    end
    kind_sel = $urandom_range(5);
    case (kind_sel)
      0: ctl = {7'($urandom), 1'b0};
      1: ctl = {6'($urandom), 2'b01};
      2: ctl = {6'($urandom), 2'b11};
      3: ctl = $urandom_range(1) ? 8'h03 : 8'h13;
      4: ctl = $urandom_range(1) ? 8'hAF : 8'hBF;
      default: ctl = 8'($urandom);
    endcase
    frame_bytes.insert(frame_bytes.size(), ctl);
    repeat ($urandom_range(0, 6)) frame_bytes.insert(frame_bytes.size(), 8'($urandom));
    while (frame_bytes.size() < pad_to) frame_bytes.insert(frame_bytes.size(), 8'($urandom));
    full = frame_bytes.size();
    if ($urandom_range(4) == 0)
      while (frame_bytes.size() > $urandom_range(1, full)) void'(frame_bytes.pop_back());
  endtask

  task automatic send_frame(input int pad_to);
    int n;
    build_frame(pad_to);
    n = frame_bytes.size();
    for (int i = 0; i < n; i++) send_byte(frame_bytes[i], i == n - 1, 1'b0);
  endtask

  // result check, receiver stall and watchdog
  always @(posedge clk) begin
    parse_result_t got, want;
    if (!rst) begin
      got = {kind, frame_type, call_a, ssid_a, call_b, ssid_b, flags,
             control_word, pid, info_start, info_count, last};
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected item: %h", got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: kind %0d/%0d type %0d/%0d call_a %h/%h ssid_a %h/%h",
                       want.kind, got.kind, want.frame_type, got.frame_type,
                       want.call_a, got.call_a, want.ssid_a, got.ssid_a);
            if (mismatches <= 10)
              $display("  call_b %h/%h ssid_b %h/%h flags %h/%h ctrl %h/%h pid %h/%h",
                       want.call_b, got.call_b, want.ssid_b, got.ssid_b, want.flags,
                       got.flags, want.control_word, got.control_word, want.pid, got.pid);
            if (mismatches <= 10)
              $display("  info_start %0d/%0d info_count %0d/%0d last %b/%b",
                       want.info_start, got.info_start, want.info_count, got.info_count,
                       want.last, got.last);
          end
        end
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
        $display("timeout: no progress for %0d cycles", WATCHDOG);
        $display("FAIL ax25_frame_header_parser");
        $finish;
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  stim_row_t directed[$];

  initial begin
    logic [7:0] hdr[15];
    ext_mode = 1'b0;
    clear_parser();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // short frames rejected outright
    directed.insert(directed.size(), stim_row_t'{8'hFF, 1'b1, 1'b1});
    directed.insert(directed.size(), stim_row_t'{8'h00, 1'b1, 1'b1});
    // minimal UI frame, source carries the end-of-address bit
    hdr = '{8'hFF, 8'hFE, 8'h00, 8'h01, 8'h80, 8'h7F, 8'hE0,
            8'h01, 8'hFE, 8'hFF, 8'h00, 8'h7F, 8'h80, 8'h61, 8'h03};
    foreach (hdr[i]) directed.insert(directed.size(), stim_row_t'{hdr[i], i == 14, 1'b0});
    // 14 bytes: one short of the minimum
    for (int i = 0; i < 14; i++)
      directed.insert(directed.size(), stim_row_t'{hdr[i], i == 13, i == 13});

    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin send_idle = 23; recv_idle = 48; end
        1: begin send_idle = 48; recv_idle = 23; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      drain();
      write_ext(ph == 1 || ph == 2 || ph == 5);
      if (ph == 0)
        foreach (directed[i]) send_byte(directed[i].b, directed[i].eof, directed[i].typed_reject);
      for (int f = 0; f < 2; f++) begin
        send_frame(0);
        if (ph == 1 && f == 0) drain();
      end
    end
    drain();

    $display("%0d frames, %0d bytes, %0d results checked, %0d mismatches",
             frames_sent, bytes_sent, results_seen, mismatches);
    $display("covered short, truncated, noise, hop-overflow and missing-end frames");
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("PASS ax25_frame_header_parser");
    end else begin
      $display("FAIL ax25_frame_header_parser");
    end
    $finish;
  end
endmodule
